### hw/rtl/acpd_pkg.sv
// Shared types and constants for the ASCII to packed-decimal converter.
package acpd_pkg;

   localparam int MAX_DIGITS = 31;
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int TOT_W      = CNT_W + 1;
   localparam int PREC_W     = 5;
   localparam int PREC_MAX   = 31;
   localparam int BYTE_W     = PREC_W - 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRECISION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO      = 2'd2;

   localparam logic [PREC_W-1:0] PRECISION_RESET = 5'd15;
   localparam logic [PREC_W-1:0] SCALE_RESET     = 5'd0;
   localparam logic              AUTO_RESET      = 1'b1;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [3:0] SIGN_PLUS  = 4'hC;
   localparam logic [3:0] SIGN_MINUS = 4'hD;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_SIGNED,
      PH_INT,
      PH_FRAC,
      PH_DONE
   } parse_phase_type;

   typedef enum logic {
      EM_IDLE,
      EM_EMIT
   } emit_state_type;

   typedef enum logic [1:0] {
      NS_ZERO,
      NS_DIGIT,
      NS_SIGN
   } nib_sel_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0]        packed_byte;
      logic              last_byte;
      logic              status;
      logic [PREC_W-1:0] used_precision;
      logic [PREC_W-1:0] used_scale;
   } rsp_type;

   typedef struct packed {
      logic [PREC_W-1:0] precision_setting;
      logic [PREC_W-1:0] scale_setting;
      logic              auto_format;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] int_count;
      logic [CNT_W-1:0] frac_count;
      logic [3:0]       sign_code;
      logic             overflow_flag;
   } num_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [3:0]       data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr_hi;
      logic [IDX_W-1:0] addr_lo;
   } ram_rd_type;

endpackage

### hw/rtl/acpd_digit_ram.sv
// Digit store: one write port, two registered read ports.
module acpd_digit_ram (
   input  logic                clock,
   input  acpd_pkg::ram_wr_type wr,
   input  acpd_pkg::ram_rd_type rd,
   output logic [3:0]          rd_data_hi,
   output logic [3:0]          rd_data_lo
);
   import acpd_pkg::*;

   logic [3:0] mem [MAX_DIGITS];
   logic [3:0] rd_hi_ff;
   logic [3:0] rd_lo_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // hold read data while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_hi_ff <= mem[rd.addr_hi];
         rd_lo_ff <= mem[rd.addr_lo];
      end
   end

   assign rd_data_hi = rd_hi_ff;
   assign rd_data_lo = rd_lo_ff;

endmodule

### hw/rtl/acpd_parse.sv
// Character parser: sign, integer and fraction digits into the digit store.
module acpd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  acpd_pkg::req_type    req,
   output acpd_pkg::ram_wr_type wr,
   output logic                 done,
   output acpd_pkg::num_type    num
);
   import acpd_pkg::*;

   parse_phase_type  phase_ff, phase_in;
   logic [CNT_W-1:0] int_ff, int_in;
   logic [CNT_W-1:0] frac_ff, frac_in;
   logic [3:0]       sign_ff, sign_in;
   logic             ovf_ff, ovf_in;
   logic             done_ff, done_in;
   num_type          num_ff, num_in;

   logic             is_digit;
   logic             int_path;
   logic             take;
   logic             take_frac;
   logic [TOT_W-1:0] idx;

   assign is_digit = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);
   assign idx      = TOT_W'(int_ff) + TOT_W'(frac_ff);

   // a non-space, non-sign first character is handled as after a sign
   assign int_path = (phase_ff == PH_SIGNED) || (phase_ff == PH_INT) ||
                     ((phase_ff == PH_SKIP) && (req.char_code != CH_SPACE) &&
                      (req.char_code != CH_MINUS) && (req.char_code != CH_PLUS));

   always_comb begin
      phase_in  = phase_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      sign_in   = sign_ff;
      ovf_in    = ovf_ff;
      done_in   = 1'b0;
      num_in    = num_ff;
      take      = 1'b0;
      take_frac = 1'b0;
      wr        = '0;
      if (accept) begin
         if (int_path) begin
            if (is_digit) begin
               take     = 1'b1;
               phase_in = PH_INT;
            end else if (req.char_code == CH_POINT) begin
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_DONE;
            end
         end else if (phase_ff == PH_SKIP) begin
            if (req.char_code == CH_MINUS) begin
               sign_in  = SIGN_MINUS;
               phase_in = PH_SIGNED;
            end else if (req.char_code == CH_PLUS) begin
               sign_in  = SIGN_PLUS;
               phase_in = PH_SIGNED;
            end
         end else if (phase_ff == PH_FRAC) begin
            if (is_digit) begin
               take      = 1'b1;
               take_frac = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end

         if (take) begin
            if (idx < TOT_W'(MAX_DIGITS)) begin
               wr.en   = 1'b1;
               wr.addr = IDX_W'(idx);
               wr.data = req.char_code[3:0];
               if (take_frac) begin
                  frac_in = frac_ff + 1'b1;
               end else begin
                  int_in = int_ff + 1'b1;
               end
            end else begin
               ovf_in = 1'b1;
            end
         end

         // hand the finished number over and clear for the next one
         if (req.last_char) begin
            done_in              = 1'b1;
            num_in.int_count     = int_in;
            num_in.frac_count    = frac_in;
            num_in.sign_code     = sign_in;
            num_in.overflow_flag = ovf_in;
            phase_in             = PH_SKIP;
            int_in               = '0;
            frac_in              = '0;
            sign_in              = SIGN_PLUS;
            ovf_in               = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         int_ff   <= '0;
         frac_ff  <= '0;
         sign_ff  <= SIGN_PLUS;
         ovf_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         sign_ff  <= sign_in;
         ovf_ff   <= ovf_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
   end

   assign done = done_ff;
   assign num  = num_ff;

endmodule

### hw/rtl/acpd_emit.sv
// Format setup, byte sequencer with digit reads, and output register.
module acpd_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  acpd_pkg::cfg_type    cfg,
   input  logic                 done,
   input  acpd_pkg::num_type    num,
   output acpd_pkg::ram_rd_type rd,
   input  logic [3:0]           rd_data_hi,
   input  logic [3:0]           rd_data_lo,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output acpd_pkg::rsp_type    rsp_data
);
   import acpd_pkg::*;

   typedef struct packed {
      nib_sel_type      sel;
      logic [IDX_W-1:0] addr;
   } nib_req_type;

   typedef struct packed {
      nib_sel_type       sel_hi;
      nib_sel_type       sel_lo;
      logic              last;
      logic              status;
      logic [PREC_W-1:0] prec;
      logic [PREC_W-1:0] scale;
      logic [3:0]        sign_nib;
   } stage_type;

   emit_state_type    state_ff, state_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // format of the number being emitted
   logic [PREC_W-1:0] prec_ff;
   logic [PREC_W-1:0] scale_ff;
   logic              ovf_ff;
   logic              lead_ff;
   logic [PREC_W-1:0] blanks_ff;
   logic [TOT_W-1:0]  tot_ff;
   logic [3:0]        sign_nib_ff;
   logic [BYTE_W-1:0] last_byte_ff;

   logic [TOT_W-1:0]  tot;
   logic [PREC_W-1:0] prec_c;
   logic [PREC_W-1:0] scale_c;
   logic [PREC_W-1:0] diff_ps;
   logic              ovf_c;
   logic              s1_move;
   logic              issue;
   nib_req_type       nib_hi;
   nib_req_type       nib_lo;

   function automatic nib_req_type pick_nib(
      input logic [PREC_W-1:0] pos,
      input logic              lead,
      input logic [PREC_W-1:0] prec,
      input logic              ovf,
      input logic [PREC_W-1:0] blanks,
      input logic [TOT_W-1:0]  total
   );
      nib_req_type       r;
      logic [PREC_W-1:0] d;
      logic [PREC_W-1:0] k;
      r.sel  = NS_ZERO;
      r.addr = '0;
      d      = pos - PREC_W'(lead);
      k      = d - blanks;
      if ((PREC_W + 1)'(pos) == (PREC_W + 1)'(prec) + (PREC_W + 1)'(lead)) begin
         r.sel = NS_SIGN;
      end else if ((pos >= PREC_W'(lead)) && !ovf && (d >= blanks) &&
                   (TOT_W'(k) < total) && (k < PREC_W'(MAX_DIGITS))) begin
         r.sel  = NS_DIGIT;
         r.addr = IDX_W'(k);
      end
      return r;
   endfunction

   function automatic logic [3:0] nib_value(
      input nib_sel_type sel,
      input logic [3:0]  digit,
      input logic [3:0]  sign_nib
   );
      logic [3:0] v;
      unique case (sel)
         NS_DIGIT: v = digit;
         NS_SIGN:  v = sign_nib;
         default:  v = 4'h0;
      endcase
      return v;
   endfunction

   // precision and scale from the digit counts or from the settings
   always_comb begin
      tot     = TOT_W'(num.int_count) + TOT_W'(num.frac_count);
      ovf_c   = num.overflow_flag;
      prec_c  = cfg.precision_setting;
      scale_c = cfg.scale_setting;
      if (cfg.auto_format) begin
         if (tot > TOT_W'(PREC_MAX)) begin
            ovf_c   = 1'b1;
            prec_c  = PREC_W'(PREC_MAX);
            scale_c = (num.frac_count > PREC_MAX) ? PREC_W'(PREC_MAX) :
                      PREC_W'(num.frac_count);
         end else begin
            prec_c  = PREC_W'(tot);
            scale_c = PREC_W'(num.frac_count);
         end
      end
      diff_ps = prec_c - scale_c;
      if ((scale_c > prec_c) || (num.int_count > diff_ps) ||
          (num.frac_count > scale_c)) begin
         ovf_c = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         prec_ff      <= prec_c;
         scale_ff     <= scale_c;
         ovf_ff       <= ovf_c;
         lead_ff      <= ~prec_c[0];
         blanks_ff    <= ovf_c ? '0 : (diff_ps - PREC_W'(num.int_count));
         tot_ff       <= tot;
         sign_nib_ff  <= ovf_c ? SIGN_PLUS : num.sign_code;
         last_byte_ff <= prec_c[PREC_W-1:1];
      end
   end

   assign nib_hi = pick_nib({byte_ff, 1'b0}, lead_ff, prec_ff, ovf_ff, blanks_ff, tot_ff);
   assign nib_lo = pick_nib({byte_ff, 1'b1}, lead_ff, prec_ff, ovf_ff, blanks_ff, tot_ff);

   assign s1_move = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue   = (state_ff == EM_EMIT) && (!s1_valid_ff || s1_move);

   assign rd.en      = issue;
   assign rd.addr_hi = nib_hi.addr;
   assign rd.addr_lo = nib_lo.addr;

   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (done) begin
               state_in = EM_EMIT;
               byte_in  = '0;
            end
         end
         EM_EMIT: begin
            if (issue) begin
               if (byte_ff == last_byte_ff) begin
                  state_in = EM_IDLE;
                  byte_in  = '0;
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
            byte_in  = '0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in     = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_in           = s1_ff;
      if (issue) begin
         s1_in.sel_hi   = nib_hi.sel;
         s1_in.sel_lo   = nib_lo.sel;
         s1_in.last     = (byte_ff == last_byte_ff);
         s1_in.status   = ovf_ff;
         s1_in.prec     = prec_ff;
         s1_in.scale    = scale_ff;
         s1_in.sign_nib = sign_nib_ff;
      end
      rsp_valid_in = s1_move ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (s1_move) begin
         rsp_in.packed_byte    = {nib_value(s1_ff.sel_hi, rd_data_hi, s1_ff.sign_nib),
                                  nib_value(s1_ff.sel_lo, rd_data_lo, s1_ff.sign_nib)};
         rsp_in.last_byte      = s1_ff.last;
         rsp_in.status         = s1_ff.status;
         rsp_in.used_precision = s1_ff.prec;
         rsp_in.used_scale     = s1_ff.scale;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         byte_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_ff      <= byte_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff == EM_EMIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_when_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff == EM_IDLE))
      else $error("number finished while bytes still being emitted");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("read stage dropped while output blocked");

   a_last_issue_idle: assert property (@(posedge clock) disable iff (reset)
      (issue && (byte_ff == last_byte_ff)) |=> (state_ff == EM_IDLE))
      else $error("sequencer kept running after the final byte");

   a_byte_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EM_EMIT) |-> (byte_ff <= last_byte_ff))
      else $error("byte counter ran past the final byte");

   a_sign_on_last: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.last) |-> (s1_ff.sel_lo == NS_SIGN))
      else $error("final byte without sign nibble");

endmodule

### hw/rtl/ascii_to_packed_decimal.sv
// Top level: ASCII decimal string to packed-decimal bytes, with register port.
//
//  channel  direction  handshake           payload
//  req_     in         req_valid/req_stall req_data (char_code, last_char)
//  rsp_     out        rsp_valid/rsp_stall rsp_data (packed_byte, last_byte, status,
//                                          used_precision, used_scale)
//  csr_     in         csr_valid/csr_ready csr_index, csr_data
//
// Characters transfer one per cycle into the digit store memory while the input is not stalled.
// After the final character the block stalls the input while it sets up
// the format (P = precision applied) and then issues one byte per cycle,
// when the output is not stalled, through the two-port digit read, P/2 + 1 bytes in all.
// Output stalls hold the byte sequencer; the output register keeps one byte.
// Reset is synchronous; the digit store needs no clearing pass.
module ascii_to_packed_decimal (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  acpd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output acpd_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [acpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [acpd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import acpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   ram_wr_type wr;
   ram_rd_type rd;
   logic [3:0] rd_data_hi;
   logic [3:0] rd_data_lo;
   logic       done;
   num_type    num;
   logic       busy;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_stall = done || busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRECISION: cfg_in.precision_setting = PREC_W'(csr_data);
            CSR_SCALE:     cfg_in.scale_setting     = PREC_W'(csr_data);
            CSR_AUTO:      cfg_in.auto_format       = csr_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.precision_setting <= PRECISION_RESET;
         cfg_ff.scale_setting     <= SCALE_RESET;
         cfg_ff.auto_format       <= AUTO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acpd_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .wr     (wr),
      .done   (done),
      .num    (num)
   );

   acpd_digit_ram u_ram (
      .clock      (clock),
      .wr         (wr),
      .rd         (rd),
      .rd_data_hi (rd_data_hi),
      .rd_data_lo (rd_data_lo)
   );

   acpd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .done       (done),
      .num        (num),
      .rd         (rd),
      .rd_data_hi (rd_data_hi),
      .rd_data_lo (rd_data_lo),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

### test/tb_ascii_to_packed_decimal.sv
// Self-checking testbench for the ASCII to packed-decimal converter.
`timescale 1ns / 1ps

module tb_ascii_to_packed_decimal;
   import acpd_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_CHARS   = 22;
   localparam int NUM_SETTINGS  = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   ascii_to_packed_decimal dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus and expectations
   req_type   char_queue[$];
   rsp_type   want_bytes[$];
   rsp_type   want_byte;

   bit        idle_on = 1'b0;
   int        hold_requests = 0;
   int        holds_done;
   int        hold_left;
   int        recv_wait;
   int        send_wait;
   int        cycle_count = 0;

   int        chars_queued = 0;
   int        numbers_done = 0;
   int        bytes_checked = 0;
   int        ovf_numbers = 0;
   int        bad_count = 0;

   // predictor state
   logic [PREC_W-1:0] prec_cfg;
   logic [PREC_W-1:0] scale_cfg;
   logic              auto_cfg;
   logic [3:0]        digit_copy [MAX_DIGITS];
   int                int_n;
   int                frac_n;
   logic [3:0]        sign_nib;
   logic              ovf_seen;
   parse_phase_type   phase;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   task automatic clear_number();
      int_n    = 0;
      frac_n   = 0;
      sign_nib = SIGN_PLUS;
      ovf_seen = 1'b0;
      phase    = PH_SKIP;
   endtask

   task automatic store_digit(input logic [7:0] c, input bit frac);
      if (int_n + frac_n < MAX_DIGITS) begin
         digit_copy[int_n + frac_n] = c[3:0];
         if (frac) frac_n++;
         else int_n++;
      end else begin
         ovf_seen = 1'b1;
      end
   endtask

   // format the parsed number into its expected packed bytes
   task automatic emit_number();
      int         p, s, tot, lead, nn, nbytes, blanks, pos, d, k;
      bit         ovf;
      logic [3:0] nib;
      logic [7:0] byte_v;
      rsp_type    r;
      ovf = ovf_seen;
      tot = int_n + frac_n;
      if (auto_cfg) begin
         if (tot > PREC_MAX) begin
            ovf = 1'b1;
            p   = PREC_MAX;
            s   = (frac_n > PREC_MAX) ? PREC_MAX : frac_n;
         end else begin
            p = tot;
            s = frac_n;
         end
      end else begin
         p = prec_cfg;
         s = scale_cfg;
      end
      if (!ovf && (s > p || int_n > p - s || frac_n > s)) ovf = 1'b1;
      lead   = (p % 2 == 0) ? 1 : 0;
      nn     = lead + p + 1;
      nbytes = nn / 2;
      blanks = ovf ? 0 : p - s - int_n;
      for (int b = 0; b < nbytes; b++) begin
         byte_v = '0;
         for (int h = 0; h < 2; h++) begin
            pos = 2 * b + h;
            nib = 4'h0;
            if (pos == nn - 1) begin
               nib = ovf ? SIGN_PLUS : sign_nib;
            end else if (pos >= lead && !ovf) begin
               d = pos - lead;
               if (d >= blanks) begin
                  k = d - blanks;
                  if (k < tot && k < MAX_DIGITS) nib = digit_copy[k];
               end
            end
            byte_v = {byte_v[3:0], nib};
         end
         r.packed_byte    = byte_v;
         r.last_byte      = (b == nbytes - 1);
         r.status         = ovf;
         r.used_precision = p[PREC_W-1:0];
         r.used_scale     = s[PREC_W-1:0];
         want_bytes.push_back(r);
      end
      numbers_done++;
      if (ovf) ovf_numbers++;
      clear_number();
   endtask

   task automatic take_char(input req_type it);
      logic [7:0] c;
      bit         is_dig;
      c      = it.char_code;
      is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
      if (phase == PH_SKIP && c == CH_SPACE) begin
         // drop leading space
      end else if (phase == PH_SKIP && (c == CH_MINUS || c == CH_PLUS)) begin
         sign_nib = (c == CH_MINUS) ? SIGN_MINUS : SIGN_PLUS;
         phase    = PH_SIGNED;
      end else if (phase == PH_SKIP || phase == PH_SIGNED || phase == PH_INT) begin
         if (is_dig) begin
            store_digit(c, 1'b0);
            phase = PH_INT;
         end else if (c == CH_POINT) begin
            phase = PH_FRAC;
         end else begin
            phase = PH_DONE;
         end
      end else if (phase == PH_FRAC) begin
         if (is_dig) store_digit(c, 1'b1);
         else phase = PH_DONE;
      end
      if (it.last_char) emit_number();
   endtask

   task automatic report_bad(input string why, input rsp_type want, input rsp_type got);
      bad_count++;
      if (bad_count <= 10)
         $display({"%s (byte/last/status/prec/scale): expected %02h/%0b/%0b/%0d/%0d",
                   " got %02h/%0b/%0b/%0d/%0d"},
                  why, want.packed_byte, want.last_byte, want.status, want.used_precision,
                  want.used_scale, got.packed_byte, got.last_byte, got.status,
                  got.used_precision, got.used_scale);
   endtask

   // monitor: track register writes, predict on each accepted char, check results
   always @(posedge clock) begin
      if (reset) begin
         prec_cfg  = PRECISION_RESET;
         scale_cfg = SCALE_RESET;
         auto_cfg  = AUTO_RESET;
         clear_number();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PRECISION: prec_cfg = csr_data;
               CSR_SCALE:     scale_cfg = csr_data;
               CSR_AUTO:      auto_cfg = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (want_bytes.size() == 0) begin
               report_bad("unexpected result", '0, rsp_data);
            end else begin
               want_byte = want_bytes.pop_front();
               bytes_checked++;
               if (rsp_data.packed_byte !== want_byte.packed_byte ||
                   rsp_data.last_byte !== want_byte.last_byte ||
                   rsp_data.status !== want_byte.status ||
                   rsp_data.used_precision !== want_byte.used_precision ||
                   rsp_data.used_scale !== want_byte.used_scale)
                  report_bad("mismatch", want_byte, rsp_data);
            end
         end
         if (req_valid && !req_stall) take_char(req_data);
      end
   end

   // driver: hold a stalled char, otherwise advance, after a random gap when idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (send_wait != 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (char_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= char_queue.pop_front();
            send_wait <= idle_on ? int'($urandom_range(0, 4)) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall after each transfer when idle_on is set, plus long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         recv_wait  <= 0;
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left != 1);
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         if (idle_on) begin
            recv_wait <= $urandom_range(0, 4);
            rsp_stall <= ($urandom_range(0, 1) != 0);
         end else begin
            recv_wait <= 0;
            rsp_stall <= 1'b0;
         end
      end else if (recv_wait != 0) begin
         recv_wait <= recv_wait - 1;
         rsp_stall <= (recv_wait != 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_text(input byte unsigned text[$]);
      req_type it;
      foreach (text[i]) begin
         it.char_code = text[i];
         it.last_char = (i == text.size() - 1);
         char_queue.push_back(it);
         chars_queued++;
      end
   endtask

   task automatic queue_string(input string t);
      byte unsigned text[$];
      for (int i = 0; i < t.len(); i++) text.push_back(t[i]);
      queue_text(text);
   endtask

   // mostly well-formed numbers with random content, some noise and broken strings
   task automatic queue_random_number();
      byte unsigned text[$];
      int           kind, n;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         n = $urandom_range(1, 6);
         repeat (n) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) text.push_back(CH_SPACE);
         case ($urandom_range(0, 2))
            0: text.push_back(CH_MINUS);
            1: text.push_back(CH_PLUS);
            default: ;
         endcase
         n = (kind == 9) ? $urandom_range(26, 34) : $urandom_range(0, 5);
         repeat (n) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         if ($urandom_range(0, 2) != 0) begin
            text.push_back(CH_POINT);
            n = (kind == 9) ? $urandom_range(0, 8) : $urandom_range(0, 4);
            repeat (n) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         end
         if ($urandom_range(0, 4) == 0) text.push_back(8'($urandom_range(0, 255)));
         if (text.size() == 0) text.push_back(CH_SPACE);
         // break the sequence at a random spot
         if (kind == 3) text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      queue_text(text);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every char is transferred and every byte has come back
   task automatic drain();
      while (char_queue.size() != 0 || req_valid || want_bytes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int           set_prec  [NUM_SETTINGS];
      int           set_scale [NUM_SETTINGS];
      int           set_auto  [NUM_SETTINGS];
      int           start;
      byte unsigned raw[$];
      set_prec  = '{15, 31, 0, 31, 7, 20, 12, 0};
      set_scale = '{2, 0, 0, 31, 3, 25, 4, 0};
      set_auto  = '{0, 0, 0, 0, 0, 0, 1, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under reset defaults (auto format)
      queue_string("-12.5");
      queue_string("  +7");
      queue_string(" ");
      queue_string("-");
      queue_string("9a3");
      queue_string("+ 5");
      queue_string(".25");
      queue_string("7.");
      raw = '{8'hFF};
      queue_text(raw);
      raw = '{8'h00, 8'h31};
      queue_text(raw);
      drain();

      set_prec[NUM_SETTINGS-1]  = $urandom_range(0, 31);
      set_scale[NUM_SETTINGS-1] = $urandom_range(0, 31);
      set_auto[NUM_SETTINGS-1]  = $urandom_range(0, 1);
      for (int i = 0; i < NUM_SETTINGS; i++) begin
         write_csr(CSR_PRECISION, CSR_DATA_W'(set_prec[i]));
         write_csr(CSR_SCALE, CSR_DATA_W'(set_scale[i]));
         write_csr(CSR_AUTO, CSR_DATA_W'(set_auto[i]));
         idle_on = (i % 3 != 2);
         start = chars_queued;
         while (chars_queued - start < PHASE_CHARS / 2) queue_random_number();
         if (i == 1) hold_requests++;
         if (i == 4) drain();
         while (chars_queued - start < PHASE_CHARS) queue_random_number();
         drain();
      end

      $display("run covered %0d chars forming %0d numbers over %0d register settings",
               chars_queued, numbers_done, NUM_SETTINGS + 1);
      $display("checked %0d packed bytes, %0d numbers flagged as not fitting",
               bytes_checked, ovf_numbers);
      if (bad_count == 0 && want_bytes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
